/* rtl/atm_pkg.sv */
package atm_pkg;

  localparam int IN_W    = 16;
  localparam int PITCH_W = 15;
  localparam int ROLL_W  = 16;
  localparam int MAG_W   = 15;
  localparam int FS_W    = 2;
  localparam int SQ_W    = 31;
  localparam int SUM_W   = 32;
  localparam int PROD_W  = 54;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int SIDE_W  = 3 * IN_W;
  localparam int VEC_W   = 36;
  localparam int ACC_W   = 26;
  localparam int ANG_W   = 16;
  localparam int TAB_N   = 24;

  localparam int ANGLE_MAX = 18000;
  localparam int PITCH_MAX = 9000;
  localparam int RIGHT_ANG = 9000;
  localparam int ACC_FRAC  = 8;

  localparam logic [PROD_W-1:0] MAG_K2      = PROD_W'(4000000);
  localparam logic [ROOT_W-1:0] MAG_HALF    = ROOT_W'(16384);
  localparam int                MAG_SHIFT   = 15;
  localparam logic [MAG_W-1:0]  MAG_MAX     = '1;

  localparam logic CFG_IDX_FULL_SCALE = 1'b0;

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  function automatic acc_t atm_atan(input int i);
    acc_t v;
    case (i)
      0:       v = acc_t'(1152000);
      1:       v = acc_t'(680065);
      2:       v = acc_t'(359328);
      3:       v = acc_t'(182400);
      4:       v = acc_t'(91554);
      5:       v = acc_t'(45822);
      6:       v = acc_t'(22916);
      7:       v = acc_t'(11459);
      8:       v = acc_t'(5730);
      9:       v = acc_t'(2865);
      10:      v = acc_t'(1432);
      11:      v = acc_t'(716);
      12:      v = acc_t'(358);
      13:      v = acc_t'(179);
      14:      v = acc_t'(90);
      15:      v = acc_t'(45);
      16:      v = acc_t'(22);
      17:      v = acc_t'(11);
      18:      v = acc_t'(6);
      19:      v = acc_t'(3);
      20:      v = acc_t'(1);
      21:      v = acc_t'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/atm_in_if.sv */
interface atm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

/* rtl/atm_out_if.sv */
interface atm_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch;
  logic signed [15:0] roll;
  logic        [14:0] magnitude;

  modport source (output valid, pitch, roll, magnitude, input ready);
  modport sink (input valid, pitch, roll, magnitude, output ready);
endinterface

/* rtl/atm_root.sv */
module atm_root import atm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         v_in,
  input  logic [1:0][RAD_W-1:0]        rad_in,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         v_out,
  output logic [1:0][ROOT_W-1:0]       root_out,
  output logic [SIDE_W-1:0]            side_out
);

  localparam int NR = ROOT_W;

  logic                   v_r    [NR];
  logic [1:0][RAD_W-1:0]  rem_r  [NR];
  logic [1:0][ROOT_W-1:0] rt_r   [NR];
  logic [SIDE_W-1:0]      side_r [NR];

  for (genvar g = 0; g < NR; g++) begin : g_stage
    localparam int J = NR - 1 - g;

    logic                   v_i;
    logic [1:0][RAD_W-1:0]  rem_i;
    logic [1:0][RAD_W-1:0]  rem_nxt;
    logic [1:0][ROOT_W-1:0] rt_i;
    logic [1:0][ROOT_W-1:0] rt_nxt;
    logic [SIDE_W-1:0]      side_i;
    logic [RAD_W+1:0]       term [2];

    if (g == 0) begin : g_first
      assign v_i    = v_in;
      assign rem_i  = rad_in;
      assign rt_i   = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign v_i    = v_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign rt_i   = rt_r[g-1];
      assign side_i = side_r[g-1];
    end

    // one root bit per stage
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        term[l] = ((RAD_W+2)'(rt_i[l]) << (J + 1)) | ((RAD_W+2)'(1) << (2 * J));
        if ({2'b00, rem_i[l]} >= term[l]) begin
          rem_nxt[l] = rem_i[l] - term[l][RAD_W-1:0];
          rt_nxt[l]  = rt_i[l] | (ROOT_W'(1) << J);
        end else begin
          rem_nxt[l] = rem_i[l];
          rt_nxt[l]  = rt_i[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        rt_r[g]   <= rt_nxt;
        side_r[g] <= side_i;
      end
    end
  end

  assign v_out    = v_r[NR-1];
  assign root_out = rt_r[NR-1];
  assign side_out = side_r[NR-1];

endmodule

/* rtl/atm_angle.sv */
module atm_angle import atm_pkg::*; #(
  parameter int ITER = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_in,
  input  vec_t             a_in [2],
  input  vec_t             b_in [2],
  input  logic [MAG_W-1:0] mag_in,
  output logic             v_out,
  output ang_t             ang_out [2],
  output logic [MAG_W-1:0] mag_out
);

  logic             v_r   [ITER+1];
  vec_t             a_r   [ITER+1][2];
  vec_t             b_r   [ITER+1][2];
  acc_t             acc_r [ITER+1][2];
  logic             sp_r  [ITER+1][2];
  ang_t             spv_r [ITER+1][2];
  logic [MAG_W-1:0] mag_r [ITER+1];

  vec_t a0 [2];
  vec_t b0 [2];
  acc_t acc0 [2];
  logic sp0 [2];
  ang_t spv0 [2];

  // exact axes, zero over zero, and the half-turn for a negative denominator
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      sp0[l] = (a_in[l] == '0) || (b_in[l] == '0);
      if (a_in[l] == '0) begin
        spv0[l] = b_in[l][VEC_W-1] ? ang_t'(ANGLE_MAX) : '0;
      end else begin
        spv0[l] = a_in[l][VEC_W-1] ? ang_t'(-RIGHT_ANG) : ang_t'(RIGHT_ANG);
      end
      if (b_in[l][VEC_W-1]) begin
        acc0[l] = (a_in[l] > 0) ? acc_t'(ANGLE_MAX * 256) : acc_t'(-ANGLE_MAX * 256);
        a0[l]   = -a_in[l];
        b0[l]   = -b_in[l];
      end else begin
        acc0[l] = '0;
        a0[l]   = a_in[l];
        b0[l]   = b_in[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        a_r[0][l]   <= a0[l];
        b_r[0][l]   <= b0[l];
        acc_r[0][l] <= acc0[l];
        sp_r[0][l]  <= sp0[l];
        spv_r[0][l] <= spv0[l];
      end
      mag_r[0] <= mag_in;
    end
  end

  for (genvar k = 1; k <= ITER; k++) begin : g_iter
    localparam int I = k - 1;

    vec_t a_nxt [2];
    vec_t b_nxt [2];
    acc_t acc_nxt [2];
    vec_t da [2];
    vec_t db [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        da[l] = a_r[k-1][l] >>> I;
        db[l] = b_r[k-1][l] >>> I;
        if (!a_r[k-1][l][VEC_W-1]) begin
          b_nxt[l]   = b_r[k-1][l] + da[l];
          a_nxt[l]   = a_r[k-1][l] - db[l];
          acc_nxt[l] = acc_r[k-1][l] + atm_atan(I);
        end else begin
          b_nxt[l]   = b_r[k-1][l] - da[l];
          a_nxt[l]   = a_r[k-1][l] + db[l];
          acc_nxt[l] = acc_r[k-1][l] - atm_atan(I);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          a_r[k][l]   <= a_nxt[l];
          b_r[k][l]   <= b_nxt[l];
          acc_r[k][l] <= acc_nxt[l];
          sp_r[k][l]  <= sp_r[k-1][l];
          spv_r[k][l] <= spv_r[k-1][l];
        end
        mag_r[k] <= mag_r[k-1];
      end
    end
  end

  acc_t acc_rnd [2];
  acc_t res [2];

  // round to centidegrees and clamp
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      acc_rnd[l] = acc_r[ITER][l] + acc_t'(128);
      res[l]     = acc_rnd[l] >>> ACC_FRAC;
      if (sp_r[ITER][l]) begin
        ang_out[l] = spv_r[ITER][l];
      end else if (res[l] > acc_t'(ANGLE_MAX)) begin
        ang_out[l] = ang_t'(ANGLE_MAX);
      end else if (res[l] < acc_t'(-ANGLE_MAX)) begin
        ang_out[l] = ang_t'(-ANGLE_MAX);
      end else begin
        ang_out[l] = res[l][ANG_W-1:0];
      end
    end
  end

  assign v_out   = v_r[ITER];
  assign mag_out = mag_r[ITER];

endmodule

/* rtl/accel_tilt_and_magnitude.sv */
// throughput: one item per cycle while the output is not stalled; squares, sums, scale product,
// 32 root stages, one angle setup stage, one stage per angle iteration, then the output register
// a stall at the output holds every stage in place
// reset: synchronous active-low rst_n clears all valid bits and full scale to 2 g
module accel_tilt_and_magnitude import atm_pkg::*; #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  atm_in_if.sink      in_ch,
  atm_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic            en;
  logic [FS_W-1:0] fs_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == CFG_IDX_FULL_SCALE) begin
      fs_r <= pwdata[FS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_FULL_SCALE) ? {{(32-FS_W){1'b0}}, fs_r} : '0;

  logic                  out_v_r;
  logic signed [PITCH_W-1:0] pitch_r;
  ang_t                  roll_r;
  logic [MAG_W-1:0]      mag_r;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // squares
  logic                  v1_r;
  logic [SQ_W-1:0]       x2_r, y2_r, z2_r;
  logic [SIDE_W-1:0]     xyz1_r;
  logic signed [SUM_W-1:0] x2, y2, z2;

  assign x2 = in_ch.accel_x * in_ch.accel_x;
  assign y2 = in_ch.accel_y * in_ch.accel_y;
  assign z2 = in_ch.accel_z * in_ch.accel_z;

  // sums
  logic              v2_r;
  logic [SUM_W-1:0]  yz_r, s_r;
  logic [SIDE_W-1:0] xyz2_r;
  logic [SUM_W-1:0]  yz_sum;

  assign yz_sum = SUM_W'(y2_r) + SUM_W'(z2_r);

  // scale product
  logic              v3_r;
  logic [RAD_W-1:0]  radm_r;
  logic [SUM_W-1:0]  yz3_r;
  logic [SIDE_W-1:0] xyz3_r;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(s_r) * MAG_K2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r   <= x2[SQ_W-1:0];
      y2_r   <= y2[SQ_W-1:0];
      z2_r   <= z2[SQ_W-1:0];
      xyz1_r <= {in_ch.accel_x, in_ch.accel_y, in_ch.accel_z};
      yz_r   <= yz_sum;
      s_r    <= yz_sum + SUM_W'(x2_r);
      xyz2_r <= xyz1_r;
      radm_r <= RAD_W'(prod) << {fs_r, 1'b0};
      yz3_r  <= yz_r;
      xyz3_r <= xyz2_r;
    end
  end

  logic                   vr;
  logic [1:0][RAD_W-1:0]  rad;
  logic [1:0][ROOT_W-1:0] root;
  logic [SIDE_W-1:0]      xyz_r;

  assign rad[0] = {yz3_r, {(RAD_W-SUM_W){1'b0}}};
  assign rad[1] = radm_r;

  atm_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (v3_r),
    .rad_in   (rad),
    .side_in  (xyz3_r),
    .v_out    (vr),
    .root_out (root),
    .side_out (xyz_r)
  );

  logic signed [IN_W-1:0] xr, yr, zr;
  vec_t                   a_in [2];
  vec_t                   b_in [2];
  logic [ROOT_W-1:0]      mag_sum;
  logic [ROOT_W-1:0]      mag_sh;
  logic [MAG_W-1:0]       mag_c;

  assign {xr, yr, zr} = xyz_r;
  assign a_in[0] = -vec_t'({{(VEC_W-IN_W-16){xr[IN_W-1]}}, xr, 16'h0000});
  assign b_in[0] = vec_t'({{(VEC_W-ROOT_W){1'b0}}, root[0]});
  assign a_in[1] = vec_t'({{(VEC_W-IN_W-16){yr[IN_W-1]}}, yr, 16'h0000});
  assign b_in[1] = vec_t'({{(VEC_W-IN_W-16){zr[IN_W-1]}}, zr, 16'h0000});

  assign mag_sum = root[1] + MAG_HALF;
  assign mag_sh  = mag_sum >> MAG_SHIFT;
  assign mag_c   = (mag_sh > ROOT_W'(MAG_MAX)) ? MAG_MAX : mag_sh[MAG_W-1:0];

  logic             va;
  ang_t             ang [2];
  logic [MAG_W-1:0] mag_a;

  atm_angle #(
    .ITER (ANGLE_ITERATIONS)
  ) u_angle (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (vr),
    .a_in    (a_in),
    .b_in    (b_in),
    .mag_in  (mag_c),
    .v_out   (va),
    .ang_out (ang),
    .mag_out (mag_a)
  );

  logic signed [PITCH_W-1:0] pitch_c;

  always_comb begin
    if (ang[0] > ang_t'(PITCH_MAX)) begin
      pitch_c = PITCH_W'(PITCH_MAX);
    end else if (ang[0] < ang_t'(-PITCH_MAX)) begin
      pitch_c = PITCH_W'(-PITCH_MAX);
    end else begin
      pitch_c = ang[0][PITCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_r <= pitch_c;
      roll_r  <= ang[1];
      mag_r   <= mag_a;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.pitch     = pitch_r;
  assign out_ch.roll      = roll_r;
  assign out_ch.magnitude = mag_r;

endmodule

/* rtl/atm_checker.sv */
module atm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [14:0] pitch,
  input logic signed [15:0] roll,
  input logic        [14:0] magnitude
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pitch >= -15'sd9000) && (pitch <= 15'sd9000))
    else $error("pitch out of range");

  a_roll_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (roll >= -16'sd18000) && (roll <= 16'sd18000) && (magnitude <= 15'd27713))
    else $error("roll or magnitude out of range");

endmodule

bind accel_tilt_and_magnitude atm_checker u_atm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pitch     (out_ch.pitch),
  .roll      (out_ch.roll),
  .magnitude (out_ch.magnitude)
);
